/* sv/wms_pkg.sv */
// Shared types and constants of the waypoint motion sequencer.
`default_nettype none
package wms_pkg;

	// Port and field widths
	localparam int IN_DATA_W  = 200;
	localparam int OUT_DATA_W = 104;
	localparam int CFG_IDX_W  = 3;
	localparam int ENTRY_W    = 160;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUANT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_QBUF    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL = 3'd4;

	// Request kinds
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_START = 2'd2;
	localparam logic [1:0] REQ_STOP  = 2'd3;

	// Q1.16 unity factor and largest time
	localparam logic [16:0] ONE_Q16 = 17'h10000;
	localparam logic [31:0] T_MAX   = 32'hFFFF_FFFF;

	// Divider step counts
	localparam logic [5:0] DIV_STEPS_GRID   = 6'd32;
	localparam logic [5:0] DIV_STEPS_FACTOR = 6'd16;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISP,
		ST_QDIV,
		ST_MUL,
		ST_ACC,
		ST_ENTER_RD,
		ST_ENTER,
		ST_MOVE_RD,
		ST_MOVE,
		ST_FDIV,
		ST_OUT
	} state_t;

	// Which term the shared multiplier works on
	typedef enum logic [1:0] {
		P_ADV,
		P_ADD,
		P_SUB
	} pass_t;

	typedef struct packed {
		logic        start;
		logic [5:0]  steps;
		logic [31:0] rem_init;
		logic [31:0] num;
		logic [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic        busy;
		logic [31:0] quot;
		logic [31:0] rem;
	} div_rsp_t;

endpackage
`default_nettype wire

/* sv/wms_ram.sv */
// Generic single-write, registered-read RAM.
`default_nettype none
module wms_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                clk,
	input  wire logic                                we,
	input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                    wdata,
	input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
	output logic      [WIDTH-1:0]                    rdata_q
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* sv/wms_div.sv */
// Serial restoring divider, one quotient bit per cycle.
`default_nettype none
module wms_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire wms_pkg::div_req_t  req,
	output wms_pkg::div_rsp_t       rsp
);
	import wms_pkg::*;

	logic [5:0]  cnt_q;
	logic        done_q;
	logic [31:0] rem_q;
	logic [31:0] num_q;
	logic [31:0] den_q;
	logic [31:0] quot_q;
	logic [32:0] trial;
	logic        fits;

	// trial subtract of the shifted remainder
	always_comb begin
		trial = {rem_q, num_q[31]};
		fits  = trial >= {1'b0, den_q};
	end

	// step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == 6'd1);
			if (req.start) begin
				cnt_q <= req.steps;
			end else if (cnt_q != 6'd0) begin
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	// remainder, divisor and quotient
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.rem_init;
			num_q  <= req.num;
			den_q  <= req.den;
			quot_q <= '0;
		end else if (cnt_q != 6'd0) begin
			rem_q  <= fits ? 32'(trial - {1'b0, den_q}) : trial[31:0];
			num_q  <= {num_q[30:0], 1'b0};
			quot_q <= {quot_q[30:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.busy = (cnt_q != 6'd0);
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q;
endmodule
`default_nettype wire

/* sv/waypoint_motion_sequencer.sv */
// Top level: waypoint table, sequencer, shared multiplier and divider.
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  s_tuser req_type, s_tdata entry fields
// m_*      out  m_tvalid/m_tready  m_tdata steps and status
// cfg_*    in   cfg_we             cfg_index, cfg_data
//
// Write and stop items go straight to the output; a start runs one 32-step grid
// division. A tick runs at most one 16-step factor division and up to
// nine passes of the single 32x17 multiplier, one per axis and term.
// s_tready is high only in the idle state; a result waits in the output
// register while m_tready is low. Reset clears all control state at once.
`default_nettype none
module waypoint_motion_sequencer #(
	parameter int MAX_WAYPOINTS = 16,
	parameter int COORD_BITS    = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// beat_time, entry_index, entry_wait, entry_move, entry_dx, entry_dy, entry_dz
	input  wire logic [wms_pkg::IN_DATA_W-1:0]      s_tdata,
	// req_type
	input  wire logic [1:0]                         s_tuser,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// step_x, step_y, step_z, moved, active_index, running, late_flag
	output logic [wms_pkg::OUT_DATA_W-1:0]          m_tdata,
	input  wire logic                               cfg_we,
	input  wire logic [wms_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [31:0]                        cfg_data
);
	import wms_pkg::*;

	localparam int IDX_W    = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
	localparam int SAT_BITS = (COORD_BITS < 32) ? COORD_BITS : 32;
	localparam logic signed [35:0] SAT_HI = (36'sd1 <<< (SAT_BITS - 1)) - 36'sd1;
	localparam logic signed [35:0] SAT_LO = -(36'sd1 <<< (SAT_BITS - 1));

	state_t state_q, state_d;
	pass_t  pass_q;

	// configuration
	logic [4:0]  count_q;
	logic        loop_q;
	logic [31:0] quant_q;
	logic [31:0] qbuf_q;

	// sequencing state
	logic             following_q;
	logic             started_q;
	logic [IDX_W-1:0] idx_q;
	logic [31:0]      ss_q;
	logic [31:0]      nss_q;
	logic [16:0]      lf_q;
	logic signed [31:0] mot_q [3];
	logic             moved_q;
	logic             late_q;
	logic [1:0]       axis_q;

	// latched item
	logic [1:0]  req_q;
	logic [31:0] beat_q;
	logic [3:0]  eidx_q;
	logic [31:0] ewait_q;
	logic [31:0] emove_q;
	logic [95:0] eoff_q;

	// arithmetic
	logic [16:0]        f_q;
	logic signed [49:0] prod_s1;
	logic signed [35:0] acc_q [3];
	logic               m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	// table and divider
	logic               ram_we;
	logic [ENTRY_W-1:0] rd_q;
	logic [31:0]        rd_wait, rd_move;
	logic signed [31:0] rd_off [3];
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	// derived values
	logic [31:0] n32, idx32, nxt32, eidx32;
	logic        adv_stop, tick_go, at_next;
	logic [33:0] end_sum;
	logic [31:0] enter_end;
	logic [32:0] move_at;
	logic        past_wait;
	logic [31:0] elapsed;
	logic [31:0] q_eff;
	logic [31:0] prev;
	logic [32:0] prev_next;
	logic [16:0] f_sel;
	logic signed [35:0] pos_term;
	logic signed [31:0] step_out [3];

	wms_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_WAYPOINTS)) u_table (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (eidx32[IDX_W-1:0]),
		.wdata  ({eoff_q, emove_q, ewait_q}),
		.raddr  (idx_q),
		.rdata_q(rd_q)
	);

	wms_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// field views and shared comparisons
	always_comb begin
		rd_wait   = rd_q[31:0];
		rd_move   = rd_q[63:32];
		rd_off[0] = $signed(rd_q[95:64]);
		rd_off[1] = $signed(rd_q[127:96]);
		rd_off[2] = $signed(rd_q[159:128]);
		n32       = (32'(count_q) > 32'(MAX_WAYPOINTS)) ? 32'(MAX_WAYPOINTS) : 32'(count_q);
		idx32     = 32'(idx_q);
		nxt32     = idx32 + 32'd1;
		eidx32    = 32'(eidx_q);
		adv_stop  = (nxt32 >= n32) && !loop_q;
		tick_go   = following_q && (n32 != 32'd0);
		at_next   = beat_q >= nss_q;
		end_sum   = {2'b0, nss_q} + {2'b0, rd_wait} + {2'b0, rd_move};
		enter_end = (end_sum > {2'b0, T_MAX}) ? T_MAX : end_sum[31:0];
		move_at   = {1'b0, ss_q} + {1'b0, rd_wait};
		past_wait = {1'b0, beat_q} >= move_at;
		elapsed   = beat_q - move_at[31:0];
		q_eff     = (quant_q == 32'd0) ? 32'd1 : quant_q;
		prev      = beat_q - div_rsp.rem;
		prev_next = {1'b0, prev} + {1'b0, q_eff};
		f_sel     = (pass_q == P_ADD) ? f_q : lf_q;
		pos_term  = 36'($signed(prod_s1[49:16]));
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, table write and divider requests
	always_comb begin
		state_d          = state_q;
		ram_we           = 1'b0;
		div_req.start    = 1'b0;
		div_req.steps    = DIV_STEPS_GRID;
		div_req.rem_init = '0;
		div_req.num      = beat_q;
		div_req.den      = q_eff;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_DISP;
			end
			ST_DISP: begin
				case (req_q)
					REQ_WRITE: begin
						ram_we  = eidx32 < 32'(MAX_WAYPOINTS);
						state_d = ST_OUT;
					end
					REQ_START: begin
						div_req.start = 1'b1;
						state_d       = ST_QDIV;
					end
					REQ_TICK: begin
						if (!tick_go) state_d = ST_OUT;
						else if (at_next) state_d = started_q ? ST_MUL : ST_ENTER_RD;
						else state_d = started_q ? ST_MOVE_RD : ST_OUT;
					end
					default: state_d = ST_OUT;
				endcase
			end
			ST_QDIV: begin
				if (div_rsp.done) state_d = ST_OUT;
			end
			ST_MUL: state_d = ST_ACC;
			ST_ACC: begin
				if (axis_q == 2'd2) begin
					case (pass_q)
						P_ADV:   state_d = adv_stop ? ST_OUT : ST_ENTER_RD;
						P_ADD:   state_d = ST_MUL;
						default: state_d = ST_OUT;
					endcase
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_ENTER_RD: state_d = ST_ENTER;
			ST_ENTER:    state_d = ST_MOVE;
			ST_MOVE_RD:  state_d = ST_MOVE;
			ST_MOVE: begin
				if (!past_wait) begin
					state_d = ST_OUT;
				end else if (elapsed >= rd_move) begin
					state_d = ST_MUL;
				end else begin
					div_req.start    = 1'b1;
					div_req.steps    = DIV_STEPS_FACTOR;
					div_req.rem_init = elapsed;
					div_req.num      = '0;
					div_req.den      = rd_move;
					state_d          = ST_FDIV;
				end
			end
			ST_FDIV: begin
				if (div_rsp.done) state_d = ST_MUL;
			end
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			loop_q      <= 1'b0;
			quant_q     <= 32'h0001_0000;
			qbuf_q      <= '0;
			following_q <= 1'b0;
			started_q   <= 1'b0;
			idx_q       <= '0;
			ss_q        <= '0;
			nss_q       <= '0;
			lf_q        <= '0;
			mot_q       <= '{default: '0};
			moved_q     <= 1'b0;
			late_q      <= 1'b0;
			axis_q      <= '0;
			pass_q      <= P_ADV;
			m_tvalid_q  <= 1'b0;
		end else begin
			// result beat: loaded in the output state, dropped once taken
			if (state_q == ST_OUT && (!m_tvalid_q || m_tready)) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			case (state_q)
				ST_DISP: begin
					moved_q <= 1'b0;
					late_q  <= 1'b0;
					axis_q  <= '0;
					pass_q  <= P_ADV;
					if (req_q == REQ_STOP) following_q <= 1'b0;
					if (req_q == REQ_TICK && tick_go && at_next && !started_q) begin
						started_q <= 1'b1;
						idx_q     <= '0;
					end
				end
				ST_QDIV: begin
					if (div_rsp.done) begin
						following_q <= 1'b1;
						if (div_rsp.rem <= qbuf_q) nss_q <= prev;
						else nss_q <= prev_next[32] ? T_MAX : prev_next[31:0];
					end
				end
				ST_ACC: begin
					if (axis_q == 2'd2) begin
						axis_q <= '0;
						case (pass_q)
							P_ADV: begin
								if (nxt32 >= n32) begin
									if (loop_q) begin
										idx_q <= '0;
									end else begin
										idx_q       <= IDX_W'(n32 - 32'd1);
										following_q <= 1'b0;
									end
								end else begin
									idx_q <= IDX_W'(nxt32);
								end
							end
							P_ADD: pass_q <= P_SUB;
							default: begin
								moved_q <= 1'b1;
								lf_q    <= f_q;
							end
						endcase
					end else begin
						axis_q <= axis_q + 2'd1;
					end
				end
				ST_ENTER: begin
					ss_q   <= nss_q;
					nss_q  <= enter_end;
					late_q <= beat_q >= enter_end;
					lf_q   <= '0;
					mot_q  <= rd_off;
				end
				ST_MOVE: begin
					axis_q <= '0;
					pass_q <= P_ADD;
					if (!past_wait) moved_q <= 1'b1;
				end
				default: ;
			endcase
			// the user must write registers only while idle; the block does not enforce it
			if (cfg_we) begin
				case (cfg_index)
					REG_COUNT:   count_q <= cfg_data[4:0];
					REG_LOOP:    loop_q  <= cfg_data[0];
					REG_QUANT:   quant_q <= cfg_data;
					REG_QBUF:    qbuf_q  <= cfg_data;
					REG_INITIAL: nss_q   <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// saturated steps, zero unless the tick moved
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (!moved_q) step_out[k] = '0;
			else if (acc_q[k] > SAT_HI) step_out[k] = SAT_HI[31:0];
			else if (acc_q[k] < SAT_LO) step_out[k] = SAT_LO[31:0];
			else step_out[k] = acc_q[k][31:0];
		end
	end

	// item latch, multiplier, accumulators and result
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					req_q   <= s_tuser;
					beat_q  <= s_tdata[31:0];
					eidx_q  <= s_tdata[35:32];
					ewait_q <= s_tdata[67:36];
					emove_q <= s_tdata[99:68];
					eoff_q  <= s_tdata[195:100];
				end
			end
			ST_DISP: begin
				// an advance starts from the full old offset, a plain move from zero
				for (int k = 0; k < 3; k++) acc_q[k] <= at_next ? 36'(mot_q[k]) : '0;
			end
			ST_MUL: begin
				prod_s1 <= 50'($signed(mot_q[axis_q]) * $signed({1'b0, f_sel}));
			end
			ST_ACC: begin
				if (pass_q == P_ADD) acc_q[axis_q] <= acc_q[axis_q] + pos_term;
				else acc_q[axis_q] <= acc_q[axis_q] - pos_term;
			end
			ST_MOVE: begin
				f_q <= ONE_Q16;
			end
			ST_FDIV: begin
				if (div_rsp.done) f_q <= {1'b0, div_rsp.quot[15:0]};
			end
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					m_tdata_q <= {1'b0, late_q, following_q, 4'(idx32), moved_q,
						step_out[2], step_out[1], step_out[0]};
				end
			end
			default: ;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// the divider only runs in the two division states
	a_div_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.busy |-> (state_q == ST_QDIV || state_q == ST_FDIV))
		else $error("divider busy outside a division state");

	// a moving result always belongs to a running sequence
	a_moved_running: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[96]) |-> m_tdata[101])
		else $error("moved reported while not running");

	// a late waypoint is only flagged on a tick that moved
	a_late_moved: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[102]) |-> m_tdata[96])
		else $error("late flag without movement");

	// the current entry stays inside the table
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx32 < 32'(MAX_WAYPOINTS))
		else $error("waypoint index out of range");

endmodule
`default_nettype wire

/* test/waypoint_motion_sequencer_chk.sv */
`timescale 1ns / 100ps
// Checker for the waypoint motion sequencer: predicts every result beat and compares.
`default_nettype none
module waypoint_motion_sequencer_chk
	import wms_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire logic [1:0]            s_tuser,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [OUT_DATA_W-1:0] m_tdata,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [31:0]           cfg_data,
	output int                         fail_count,
	output int                         pending,
	output int                         results_seen,
	output int                         moves_seen,
	output int                         late_seen
);

	typedef struct {
		logic [31:0] sx, sy, sz;
		logic        moved;
		logic [3:0]  idx;
		logic        run;
		logic        late;
	} step_t;

	// Register copies
	logic [4:0]  wp_count;
	logic        loop_on;
	logic [31:0] grid, grid_buf, first_start;

	// Sequencer copies
	logic [31:0] wait_tab [16];
	logic [31:0] move_tab [16];
	longint      off_tab  [16][3];
	logic        following, started;
	int          cur_idx;
	logic [31:0] seg_start, next_start;
	logic [16:0] fac_last;
	longint      motion [3];

	step_t steps_due [$];

	function automatic longint pos_at(longint m, logic [16:0] f);
		longint p;
		p = m * longint'({15'd0, f});
		return p >>> 16; // floor
	endfunction

	function automatic logic [31:0] sat32(longint v);
		if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic logic [31:0] sat_t(longint unsigned v);
		return (v > 64'hFFFF_FFFF) ? T_MAX : v[31:0];
	endfunction

	// Predict the result of one accepted request
	function automatic step_t predict_step(logic [1:0] req, logic [IN_DATA_W-1:0] d);
		step_t r;
		logic [31:0] beat;
		longint dp [3];
		longint unsigned q, prev, move_at, el, mv;
		logic [16:0] f;
		logic moved, late, go;
		int n, ix;
		beat = d[31:0];
		dp = '{0, 0, 0};
		moved = 0;
		late = 0;
		n = (wp_count < 16) ? wp_count : 16;
		case (req)
			REQ_WRITE: begin
				ix = d[35:32];
				wait_tab[ix] = d[67:36];
				move_tab[ix] = d[99:68];
				off_tab[ix][0] = longint'($signed(d[131:100]));
				off_tab[ix][1] = longint'($signed(d[163:132]));
				off_tab[ix][2] = longint'($signed(d[195:164]));
			end
			REQ_START: begin
				q = (grid != 0) ? grid : 1;
				prev = beat - (beat % q);
				following = 1;
				if (beat - prev <= grid_buf) next_start = prev[31:0];
				else next_start = sat_t(prev + q);
			end
			REQ_STOP: following = 0;
			default: begin
				if (following && n != 0) begin
					go = 1;
					if (beat >= next_start) begin
						if (!started) begin
							started = 1;
							cur_idx = 0;
						end else begin
							for (int k = 0; k < 3; k++)
								dp[k] = motion[k] - pos_at(motion[k], fac_last);
							cur_idx++;
							if (cur_idx >= n) begin
								if (loop_on) cur_idx = 0;
								else begin
									cur_idx = n - 1;
									following = 0;
								end
							end
						end
						if (!following) go = 0;
						else begin
							seg_start = next_start;
							next_start = sat_t(longint'(seg_start) + wait_tab[cur_idx]
								+ move_tab[cur_idx]);
							late = beat >= next_start;
							fac_last = 0;
							for (int k = 0; k < 3; k++) motion[k] = off_tab[cur_idx][k];
						end
					end
					if (go && started) begin
						move_at = longint'(seg_start) + wait_tab[cur_idx];
						if (beat >= move_at) begin
							el = beat - move_at;
							mv = move_tab[cur_idx];
							f = (el >= mv) ? ONE_Q16 : 17'((el << 16) / mv);
							for (int k = 0; k < 3; k++)
								dp[k] += pos_at(motion[k], f) - pos_at(motion[k], fac_last);
							fac_last = f;
						end
						moved = 1;
					end
					if (!moved) dp = '{0, 0, 0};
				end
			end
		endcase
		r.sx = sat32(dp[0]);
		r.sy = sat32(dp[1]);
		r.sz = sat32(dp[2]);
		r.moved = moved;
		r.idx = cur_idx[3:0];
		r.run = following;
		r.late = late;
		return r;
	endfunction

	task automatic report(string field, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s mismatch, got %h expected %h", $realtime, field, got, want);
		fail_count++;
	endtask

	// Compare first, then predict: a result never leaves on its own accept edge
	always @(posedge clk or negedge arst_n) begin
		step_t got, want;
		if (!arst_n) begin
			wp_count = 0;
			loop_on = 0;
			grid = 32'h10000;
			grid_buf = 0;
			first_start = 0;
			following = 0;
			started = 0;
			cur_idx = 0;
			seg_start = 0;
			next_start = 0;
			fac_last = 0;
			motion = '{0, 0, 0};
			steps_due.delete();
			fail_count = 0;
			pending = 0;
			results_seen = 0;
			moves_seen = 0;
			late_seen = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.sx = m_tdata[31:0];
				got.sy = m_tdata[63:32];
				got.sz = m_tdata[95:64];
				got.moved = m_tdata[96];
				got.idx = m_tdata[100:97];
				got.run = m_tdata[101];
				got.late = m_tdata[102];
				results_seen++;
				if (steps_due.size() == 0) begin
					$display("%0t: result beat with nothing outstanding", $realtime);
					fail_count++;
				end else begin
					want = steps_due.pop_front();
					if (got.sx !== want.sx) report("step_x", got.sx, want.sx);
					if (got.sy !== want.sy) report("step_y", got.sy, want.sy);
					if (got.sz !== want.sz) report("step_z", got.sz, want.sz);
					if (got.moved !== want.moved) report("moved", got.moved, want.moved);
					if (got.idx !== want.idx) report("active_index", got.idx, want.idx);
					if (got.run !== want.run) report("running", got.run, want.run);
					if (got.late !== want.late) report("late_flag", got.late, want.late);
					if (want.moved) moves_seen++;
					if (want.late) late_seen++;
				end
			end
			if (s_tvalid && s_tready) steps_due.push_back(predict_step(s_tuser, s_tdata));
			if (cfg_we) begin
				case (cfg_index)
					REG_COUNT: wp_count = cfg_data[4:0];
					REG_LOOP:  loop_on = cfg_data[0];
					REG_QUANT: grid = cfg_data;
					REG_QBUF:  grid_buf = cfg_data;
					REG_INITIAL: begin
						first_start = cfg_data;
						next_start = cfg_data;
					end
					default: ;
				endcase
			end
			pending = steps_due.size();
		end
	end

endmodule
`default_nettype wire

/* test/waypoint_motion_sequencer_tb.sv */
`timescale 1ns / 100ps
// Testbench top: clock, reset, request and register stimulus, verdict.
`default_nettype none
module waypoint_motion_sequencer_tb;
	import wms_pkg::*;

	logic                  clk, arst_n;
	logic                  s_tvalid, s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [1:0]            s_tuser;
	logic                  m_tvalid, m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [31:0]           cfg_data;
	int fail_count, pending, results_seen, moves_seen, late_seen;
	int burst_left, items_sent, phases_run;
	int cycles;
	logic hold_req;

	waypoint_motion_sequencer u_top (.*);

	waypoint_motion_sequencer_chk u_chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 1500000) begin
				$display("waypoint_motion_sequencer test failed");
				$finish;
			end
		end
	end

	// Result side: changing stall patterns plus one long hold-off on request
	initial begin
		int mode, left;
		logic hold_done;
		m_tready = 0;
		mode = 0;
		left = 0;
		hold_done = 0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				m_tready <= 0;
				repeat (400) @(posedge clk);
				hold_done = 1;
			end
			if (left == 0) begin
				mode = $urandom_range(0, 2);
				left = $urandom_range(5, 120);
			end
			left--;
			case (mode)
				0: m_tready <= 1;
				1: m_tready <= 1'($urandom_range(0, 1));
				default: m_tready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// Offer one request beat; sender bursts and gaps decided here
	task automatic send(logic [1:0] req, logic [31:0] beat, logic [3:0] idx = 4'($urandom),
			logic [31:0] wt = $urandom, logic [31:0] mv = $urandom,
			logic [31:0] dx = $urandom, logic [31:0] dy = $urandom,
			logic [31:0] dz = $urandom);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
			if (gap != 0) begin
				s_tvalid <= 0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		s_tvalid <= 1;
		s_tuser <= req;
		s_tdata <= {4'd0, dz, dy, dx, mv, wt, idx, beat};
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// Quiet point for register writes
	task automatic settle();
		s_tvalid <= 0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0 || !s_tready);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_time();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return T_MAX;
			2: return $urandom;
			default: return $urandom_range(0, 32'h30000);
		endcase
	endfunction

	function automatic logic [31:0] pick_offset();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom;
			default: return $urandom_range(0, 32'h60000) - 32'h30000;
		endcase
	endfunction

	initial begin
		logic [31:0] t;
		int r;
		arst_n = 0;
		s_tvalid = 0;
		s_tuser = REQ_TICK;
		s_tdata = '0;
		cfg_we = 0;
		cfg_index = REG_COUNT;
		cfg_data = 0;
		hold_req = 0;
		burst_left = 0;
		items_sent = 0;
		phases_run = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: fill the table with extreme entries
		for (int i = 0; i < 16; i++) begin
			case (i)
				0: send(REQ_WRITE, $urandom, 4'(i), 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0);
				1: send(REQ_WRITE, $urandom, 4'(i), 32'h10000, 32'h20000,
					32'h8000_0000, 32'h7FFF_FFFF, 32'h10000);
				2: send(REQ_WRITE, $urandom, 4'(i), T_MAX, T_MAX, 32'hFFFF_FFFF, 1, 0);
				default: send(REQ_WRITE, $urandom, 4'(i), $urandom_range(0, 32'h20000),
					$urandom_range(0, 32'h40000), pick_offset(), pick_offset(),
					pick_offset());
			endcase
		end
		// Tick before start, count beyond table size, start, ticks, stop
		settle();
		write_reg(REG_COUNT, 31);
		write_reg(REG_LOOP, 1);
		send(REQ_TICK, 32'h10000);
		send(REQ_START, 32'h18000);
		send(REQ_TICK, 32'h20000);
		send(REQ_TICK, 32'h20000);
		send(REQ_TICK, 32'h80000);
		send(REQ_TICK, 32'hFFFF_FFFF);
		send(REQ_STOP, 0);
		send(REQ_TICK, 32'hFFFF_FFFF);

		// Random phases, each under its own register setting
		for (int ph = 0; ph < 10; ph++) begin
			settle();
			phases_run++;
			case (ph)
				0: write_reg(REG_COUNT, 16);
				1: write_reg(REG_COUNT, 0);
				2: write_reg(REG_COUNT, 1);
				default: write_reg(REG_COUNT, $urandom_range(1, 16));
			endcase
			write_reg(REG_LOOP, ph % 2);
			case (ph % 5)
				0: write_reg(REG_QUANT, 0);
				1: write_reg(REG_QUANT, 1);
				2: write_reg(REG_QUANT, T_MAX);
				3: write_reg(REG_QUANT, 32'h10000);
				default: write_reg(REG_QUANT, $urandom_range(1, 32'h40000));
			endcase
			write_reg(REG_QBUF, ph == 3 ? T_MAX : (ph == 4 ? 0 : $urandom_range(0, 32'h20000)));
			write_reg(REG_INITIAL, ph == 5 ? T_MAX : $urandom_range(0, 32'h40000));
			t = (ph == 6) ? 32'hFFF0_0000 : $urandom_range(0, 32'h100000);
			for (int k = 0; k < 80; k++) begin
				if (ph == 4 && k == 10) hold_req <= 1;
				r = $urandom_range(0, 99);
				if (r < 8)
					send(2'($urandom_range(0, 3)), $urandom);
				else if (r < 18)
					send(REQ_WRITE, $urandom, 4'($urandom), pick_time(), pick_time(),
						pick_offset(), pick_offset(), pick_offset());
				else if (r < 22 || k == 0)
					send(REQ_START, t);
				else if (r < 24)
					send(REQ_STOP, $urandom);
				else begin
					t = (t > 32'hFFFF_FFFF - 32'h20000) ? T_MAX :
						t + $urandom_range(0, 32'h20000);
					send(REQ_TICK, t);
				end
			end
		end

		// Drain
		s_tvalid <= 0;
		do @(posedge clk); while (pending != 0);
		repeat (60) @(posedge clk);
		$display("Sent %0d requests over %0d register settings; %0d results checked",
			items_sent, phases_run + 1, results_seen);
		$display("%0d results carried motion, %0d flagged a late waypoint",
			moves_seen, late_seen);
		if (fail_count == 0)
			$display("waypoint_motion_sequencer test passed");
		else
			$display("waypoint_motion_sequencer test failed");
		$finish;
	end

endmodule
`default_nettype wire
